/* design/rmeu_pkg.sv */
// Shared types, function codes and decode helpers for the register machine execute unit.
package rmeu_pkg;

  localparam int RMEU_NUM_REGS = 16;
  localparam int RMEU_DATA_W   = 32;
  localparam int RMEU_FUNC_W   = 5;
  localparam int RMEU_REG_W    = 4;
  localparam int RMEU_ITER_W   = 5;

  localparam logic [RMEU_FUNC_W-1:0] FN_MOV_I   = 5'd0;
  localparam logic [RMEU_FUNC_W-1:0] FN_ADD_I   = 5'd1;
  localparam logic [RMEU_FUNC_W-1:0] FN_SUB_I   = 5'd2;
  localparam logic [RMEU_FUNC_W-1:0] FN_MUL_I   = 5'd3;
  localparam logic [RMEU_FUNC_W-1:0] FN_DIV_I   = 5'd4;
  localparam logic [RMEU_FUNC_W-1:0] FN_MOD_I   = 5'd5;
  localparam logic [RMEU_FUNC_W-1:0] FN_PRINT_I = 5'd6;
  localparam logic [RMEU_FUNC_W-1:0] FN_MOV_R   = 5'd7;
  localparam logic [RMEU_FUNC_W-1:0] FN_ADD_R   = 5'd8;
  localparam logic [RMEU_FUNC_W-1:0] FN_SUB_R   = 5'd9;
  localparam logic [RMEU_FUNC_W-1:0] FN_MUL_R   = 5'd10;
  localparam logic [RMEU_FUNC_W-1:0] FN_DIV_R   = 5'd11;
  localparam logic [RMEU_FUNC_W-1:0] FN_MOD_R   = 5'd12;
  localparam logic [RMEU_FUNC_W-1:0] FN_PRINT_R = 5'd13;
  localparam logic [RMEU_FUNC_W-1:0] FN_JMP     = 5'd14;
  localparam logic [RMEU_FUNC_W-1:0] FN_JEQ     = 5'd15;
  localparam logic [RMEU_FUNC_W-1:0] FN_JLT     = 5'd16;
  localparam logic [RMEU_FUNC_W-1:0] FN_JGT     = 5'd17;

  typedef struct packed {
    logic [RMEU_FUNC_W-1:0]        func;
    logic signed [RMEU_DATA_W-1:0] imm;
    logic [RMEU_REG_W-1:0]         src_reg;
    logic [RMEU_REG_W-1:0]         dst_reg;
  } rmeu_in_t;

  typedef struct packed {
    logic                          printed;
    logic signed [RMEU_DATA_W-1:0] print_value;
    logic                          status;
    logic signed [RMEU_DATA_W-1:0] pc_value;
  } rmeu_out_t;

  typedef enum logic [3:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_PRINT,
    OP_JMP, OP_JEQ, OP_JLT, OP_JGT, OP_NOP
  } rmeu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRC, ST_DST, ST_NEGB, ST_MUL, ST_DIV, ST_FIX, ST_DONE
  } rmeu_state_t;

  function automatic rmeu_op_t rmeu_decode(logic [RMEU_FUNC_W-1:0] func);
    rmeu_op_t op;
    case (func)
      FN_MOV_I, FN_MOV_R:     op = OP_MOV;
      FN_ADD_I, FN_ADD_R:     op = OP_ADD;
      FN_SUB_I, FN_SUB_R:     op = OP_SUB;
      FN_MUL_I, FN_MUL_R:     op = OP_MUL;
      FN_DIV_I, FN_DIV_R:     op = OP_DIV;
      FN_MOD_I, FN_MOD_R:     op = OP_MOD;
      FN_PRINT_I, FN_PRINT_R: op = OP_PRINT;
      FN_JMP:                 op = OP_JMP;
      FN_JEQ:                 op = OP_JEQ;
      FN_JLT:                 op = OP_JLT;
      FN_JGT:                 op = OP_JGT;
      default:                op = OP_NOP;
    endcase
    return op;
  endfunction

  function automatic logic rmeu_uses_reg(logic [RMEU_FUNC_W-1:0] func);
    return func inside {[FN_MOV_R:FN_PRINT_R]};
  endfunction

endpackage

/* design/register_machine_execute_unit_core.sv */
// Instruction execute unit: register file, program counter and a shared iterative adder.
// Every request passes source read, destination read and a done state; multiply adds 32
// shift-add passes of the shared adder, divide and modulo add sign fix-ups plus 32 restoring
// subtract passes. Division by zero skips the passes and sets the error status.
// One request at a time; the next is taken the cycle after the result is registered, and
// the done state holds while the output is stalled. Synchronous active-low reset clears the
// registers, the program counter and the output valid.
module register_machine_execute_unit_core
  import rmeu_pkg::*;
#(
  parameter int NUM_REGS = RMEU_NUM_REGS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rmeu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rmeu_out_t out_data
);

  localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DW     = RMEU_DATA_W;

  rmeu_state_t state_r, state_nxt;
  rmeu_in_t    ins_r, ins_nxt;
  rmeu_op_t    op_r, op_nxt;

  logic [DW-1:0] opnd_r, opnd_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic [DW-1:0] pval_r, pval_nxt;
  logic [DW-1:0] pc_r, pc_nxt;
  logic [RMEU_ITER_W-1:0] cnt_r, cnt_nxt;
  logic na_r, na_nxt, nb_r, nb_nxt;
  logic wr_r, wr_nxt, sts_r, sts_nxt, prt_r, prt_nxt;

  logic      out_valid_r, out_valid_nxt;
  rmeu_out_t out_data_r, out_data_nxt;

  // register file
  logic [DW-1:0]       mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [DW-1:0]       rd_data_r;
  logic                rd_hit_r;
  logic [RMEU_REG_W-1:0] rd_idx;
  logic [RIDX_W-1:0]   rd_addr, wr_addr;
  logic                rd_inrange, wr_inrange, mem_we;
  logic [DW-1:0]       regval;

  // shared adder
  logic [DW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [DW:0]   alu_sum;

  logic [DW-1:0] rem_sh, fix_x;
  logic          take, fix_neg, qbit, out_free;

  assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  assign rd_idx     = (state_r == ST_IDLE) ? in_data.src_reg : ins_r.dst_reg;
  assign rd_addr    = RIDX_W'(rd_idx);
  assign rd_inrange = (32'(rd_idx) < 32'(NUM_REGS));
  assign wr_addr    = RIDX_W'(ins_r.dst_reg);
  assign wr_inrange = (32'(ins_r.dst_reg) < 32'(NUM_REGS));
  assign regval     = rd_hit_r ? rd_data_r : '0;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rem_sh  = {acc_r[DW-2:0], quo_r[DW-1]};
  assign fix_neg = (op_r == OP_MOD) ? na_r : (na_r ^ nb_r);
  assign fix_x   = (op_r == OP_MOD) ? acc_r : quo_r;
  assign qbit    = !alu_sum[DW];

  always_comb begin
    case (op_r)
      OP_JMP:  take = 1'b1;
      OP_JEQ:  take = (regval == '0);
      OP_JLT:  take = regval[DW-1];
      OP_JGT:  take = (regval != '0) && !regval[DW-1];
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ins_nxt       = ins_r;
    op_nxt        = op_r;
    opnd_nxt      = opnd_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    res_nxt       = res_r;
    pval_nxt      = pval_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    wr_nxt        = wr_r;
    sts_nxt       = sts_r;
    prt_nxt       = prt_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ins_nxt   = in_data;
          op_nxt    = rmeu_decode(in_data.func);
          wr_nxt    = 1'b0;
          sts_nxt   = 1'b0;
          prt_nxt   = 1'b0;
          pval_nxt  = '0;
          state_nxt = ST_SRC;
        end
      end
      ST_SRC: begin
        opnd_nxt  = rmeu_uses_reg(ins_r.func) ? regval : DW'(ins_r.imm);
        state_nxt = ST_DST;
      end
      ST_DST: begin
        state_nxt = ST_DONE;
        case (op_r)
          OP_MOV: begin
            res_nxt = opnd_r;
            wr_nxt  = 1'b1;
          end
          OP_ADD, OP_SUB: begin
            alu_a   = regval;
            alu_b   = opnd_r;
            alu_sub = (op_r == OP_SUB);
            res_nxt = alu_sum[DW-1:0];
            wr_nxt  = 1'b1;
          end
          OP_MUL: begin
            acc_nxt   = '0;
            quo_nxt   = opnd_r;
            dvs_nxt   = regval;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (opnd_r == '0) begin
              sts_nxt = 1'b1;
            end else begin
              // take the dividend magnitude
              na_nxt    = regval[DW-1];
              nb_nxt    = opnd_r[DW-1];
              alu_a     = regval[DW-1] ? '0 : regval;
              alu_b     = regval[DW-1] ? regval : '0;
              alu_sub   = regval[DW-1];
              quo_nxt   = alu_sum[DW-1:0];
              state_nxt = ST_NEGB;
            end
          end
          OP_PRINT: begin
            prt_nxt  = 1'b1;
            pval_nxt = opnd_r;
          end
          OP_JMP, OP_JEQ, OP_JLT, OP_JGT: begin
            alu_a  = pc_r;
            alu_b  = take ? DW'(ins_r.imm) : DW'(1);
            pc_nxt = alu_sum[DW-1:0];
          end
          default: begin
          end
        endcase
      end
      ST_NEGB: begin
        alu_a     = nb_r ? '0 : opnd_r;
        alu_b     = nb_r ? opnd_r : '0;
        alu_sub   = nb_r;
        dvs_nxt   = alu_sum[DW-1:0];
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_MUL: begin
        // shift-add: add the shifted multiplicand where the multiplier bit is set
        alu_a   = acc_r;
        alu_b   = quo_r[0] ? dvs_r : '0;
        acc_nxt = alu_sum[DW-1:0];
        dvs_nxt = {dvs_r[DW-2:0], 1'b0};
        quo_nxt = {1'b0, quo_r[DW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          res_nxt   = alu_sum[DW-1:0];
          wr_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        // restoring step: keep the trial difference when it does not borrow
        alu_a   = rem_sh;
        alu_b   = dvs_r;
        alu_sub = 1'b1;
        acc_nxt = qbit ? alu_sum[DW-1:0] : rem_sh;
        quo_nxt = {quo_r[DW-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        alu_a     = fix_neg ? '0 : fix_x;
        alu_b     = fix_neg ? fix_x : '0;
        alu_sub   = fix_neg;
        res_nxt   = alu_sum[DW-1:0];
        wr_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          mem_we                   = wr_r && wr_inrange;
          out_valid_nxt            = 1'b1;
          out_data_nxt.printed     = prt_r;
          out_data_nxt.print_value = pval_r;
          out_data_nxt.status      = sts_r;
          out_data_nxt.pc_value    = pc_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      vld_r       <= '0;
      rd_hit_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      rd_hit_r    <= rd_inrange && vld_r[rd_addr];
      if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    op_r       <= op_nxt;
    opnd_r     <= opnd_nxt;
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    res_r      <= res_nxt;
    pval_r     <= pval_nxt;
    cnt_r      <= cnt_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    wr_r       <= wr_nxt;
    sts_r      <= sts_nxt;
    prt_r      <= prt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= res_r;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* design/rmeu_checker.sv */
// Port-level checks for the execute unit and their binding to the top level.
module rmeu_checker
  import rmeu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input rmeu_out_t out_data
);

  // busy for at least the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while the previous one was still in flight");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.printed) |-> (out_data.print_value == '0))
    else $error("print value nonzero on a non-print result");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && out_data.printed))
    else $error("error status on a print result");

endmodule

bind register_machine_execute_unit_core rmeu_checker u_rmeu_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for the register machine execute unit core.
`timescale 1ns / 100ps

module tb;
  import rmeu_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rmeu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rmeu_out_t out_data;

  register_machine_execute_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the architectural state
  logic [RMEU_DATA_W-1:0] shadow_regs [RMEU_NUM_REGS];
  logic [RMEU_DATA_W-1:0] shadow_pc;

  rmeu_in_t  instr_q[$];
  rmeu_out_t outcome_q[$];
  int        issued_cnt = 0;
  int        taken_cnt = 0;
  int        mismatch_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  // Execute one instruction on the shadow state and return its outcome.
  function automatic rmeu_out_t run_instr(rmeu_in_t ins);
    rmeu_out_t              res;
    logic [RMEU_DATA_W-1:0] opnd, d, ma, mb, q, r;
    logic                   take;
    res = '0;
    opnd = (ins.func >= FN_MOV_R && ins.func <= FN_PRINT_R) ? shadow_regs[ins.src_reg]
                                                             : ins.imm;
    d = shadow_regs[ins.dst_reg];
    case (ins.func)
      FN_MOV_I, FN_MOV_R: shadow_regs[ins.dst_reg] = opnd;
      FN_ADD_I, FN_ADD_R: shadow_regs[ins.dst_reg] = d + opnd;
      FN_SUB_I, FN_SUB_R: shadow_regs[ins.dst_reg] = d - opnd;
      FN_MUL_I, FN_MUL_R: shadow_regs[ins.dst_reg] = d * opnd;
      FN_DIV_I, FN_DIV_R, FN_MOD_I, FN_MOD_R: begin
        if (opnd == '0) begin
          res.status = 1'b1;
        end else begin
          // divide magnitudes, then restore signs (truncate toward zero)
          ma = d[RMEU_DATA_W-1] ? '0 - d : d;
          mb = opnd[RMEU_DATA_W-1] ? '0 - opnd : opnd;
          q = ma / mb;
          r = ma % mb;
          if (ins.func == FN_MOD_I || ins.func == FN_MOD_R)
            shadow_regs[ins.dst_reg] = d[RMEU_DATA_W-1] ? '0 - r : r;
          else
            shadow_regs[ins.dst_reg] =
              (d[RMEU_DATA_W-1] ^ opnd[RMEU_DATA_W-1]) ? '0 - q : q;
        end
      end
      FN_PRINT_I, FN_PRINT_R: begin
        res.printed = 1'b1;
        res.print_value = opnd;
      end
      FN_JMP, FN_JEQ, FN_JLT, FN_JGT: begin
        case (ins.func)
          FN_JMP:  take = 1'b1;
          FN_JEQ:  take = (d == '0);
          FN_JLT:  take = d[RMEU_DATA_W-1];
          default: take = (d != '0) && !d[RMEU_DATA_W-1];
        endcase
        shadow_pc = shadow_pc + (take ? ins.imm : 32'd1);
      end
      default: ;
    endcase
    res.pc_value = shadow_pc;
    return res;
  endfunction

  function automatic void push_instr(logic [RMEU_FUNC_W-1:0] func, logic [31:0] imm,
                                     int src, int dst);
    rmeu_in_t ins;
    ins.func = func;
    ins.imm = imm;
    ins.src_reg = RMEU_REG_W'(src);
    ins.dst_reg = RMEU_REG_W'(dst);
    instr_q.push_back(ins);
    issued_cnt++;
  endfunction

  task automatic queue_random(int n);
    logic [RMEU_FUNC_W-1:0] func;
    logic [31:0]            imm;
    for (int i = 0; i < n; i++) begin
      // mostly defined operations, a few unused codes
      if ($urandom_range(9) == 0)
        func = RMEU_FUNC_W'($urandom_range(31, 18));
      else
        func = RMEU_FUNC_W'($urandom_range(17, 0));
      case ($urandom_range(9))
        0, 1, 2, 3: imm = $urandom_range(16) - 8;
        4: begin
          case ($urandom_range(4))
            0:       imm = 32'h8000_0000;
            1:       imm = 32'h7fff_ffff;
            2:       imm = 32'hffff_ffff;
            3:       imm = 32'h0;
            default: imm = 32'h1;
          endcase
        end
        default: imm = $urandom();
      endcase
      push_instr(func, imm, $urandom_range(15), $urandom_range(15));
    end
  endtask

  // Wait until every request is taken and every outcome has arrived.
  task automatic drain();
    do @(negedge clk);
    while (!(taken_cnt == issued_cnt && outcome_q.size() == 0));
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(run_instr(in_data));
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (instr_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= instr_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    rmeu_out_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: printed=%0b value=%0d status=%0b pc=%0d",
                     out_data.printed, out_data.print_value, out_data.status,
                     out_data.pc_value);
        end else begin
          exp_res = outcome_q.pop_front();
          if (out_data.printed !== exp_res.printed ||
              out_data.print_value !== exp_res.print_value ||
              out_data.status !== exp_res.status ||
              out_data.pc_value !== exp_res.pc_value) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"mismatch: exp printed=%0b value=%0d status=%0b pc=%0d,",
                        " got printed=%0b value=%0d status=%0b pc=%0d"},
                       exp_res.printed, exp_res.print_value, exp_res.status,
                       exp_res.pc_value, out_data.printed, out_data.print_value,
                       out_data.status, out_data.pc_value);
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < RMEU_NUM_REGS; i++)
      shadow_regs[i] = '0;
    shadow_pc = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: wrap-around, division corners, prints, jumps, unused codes
    push_instr(FN_MOV_I, 32'h7fff_ffff, 0, 0);
    push_instr(FN_ADD_I, 32'h1, 0, 0);
    push_instr(FN_MOV_I, 32'h8000_0000, 0, 1);
    push_instr(FN_SUB_I, 32'h1, 0, 1);
    push_instr(FN_MOV_I, 32'h8000_0000, 0, 2);
    push_instr(FN_DIV_I, 32'hffff_ffff, 0, 2);
    push_instr(FN_MOV_I, 32'h8000_0000, 0, 3);
    push_instr(FN_MOD_I, 32'hffff_ffff, 0, 3);
    push_instr(FN_MOV_I, -32'sd7, 0, 4);
    push_instr(FN_DIV_I, 32'd2, 0, 4);
    push_instr(FN_MOV_I, -32'sd7, 0, 5);
    push_instr(FN_MOD_I, 32'd2, 0, 5);
    push_instr(FN_DIV_I, 32'h0, 0, 4);
    push_instr(FN_MOD_R, 32'h0, 15, 5);
    push_instr(FN_MUL_I, 32'h7fff_ffff, 0, 1);
    push_instr(FN_PRINT_I, 32'h8000_0000, 0, 0);
    push_instr(FN_PRINT_R, 32'h0, 5, 0);
    push_instr(FN_MOV_R, 32'h0, 1, 6);
    push_instr(FN_ADD_R, 32'h0, 6, 6);
    push_instr(FN_SUB_R, 32'h0, 4, 6);
    push_instr(FN_MUL_R, 32'h0, 4, 6);
    push_instr(FN_DIV_R, 32'h0, 4, 6);
    push_instr(FN_JMP, 32'h7fff_ffff, 0, 0);
    push_instr(FN_JMP, 32'h1, 0, 0);
    push_instr(FN_JEQ, -32'sd5, 0, 15);
    push_instr(FN_JEQ, 32'd9, 0, 2);
    push_instr(FN_JLT, 32'd3, 0, 2);
    push_instr(FN_JLT, 32'd3, 0, 15);
    push_instr(FN_JGT, 32'd100, 0, 6);
    push_instr(FN_JGT, 32'd100, 0, 15);
    push_instr(5'd31, 32'hffff_ffff, 15, 15);
    push_instr(5'd18, 32'h1234_5678, 0, 0);
    queue_random(490);
    drain();

    idle_pct = 85;
    queue_random(480);
    drain();

    idle_pct = 0;
    stall_pct = 85;
    queue_random(480);
    drain();

    idle_pct = 6;
    stall_pct = 6;
    queue_random(480);
    drain();

    // hold off for the longest instruction before closing
    idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && outcome_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
